FILE: hw/rtl/grid_maze_set_merger_top_macros.svh
// Assertion macros for the grid maze set merger.
// Each macro expects signals named clk and arst_n wherever it is used.
`ifndef GRID_MAZE_SET_MERGER_TOP_MACROS_SVH
`define GRID_MAZE_SET_MERGER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GMSM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define GMSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gmsm_pkg.sv
// Shared types, constants and helpers for the grid maze set merger.
// No dependencies.
package gmsm_pkg;

	localparam int SIDE      = 32;
	localparam int CELLS     = SIDE * SIDE;
	localparam int LABEL_W   = $clog2(CELLS);
	localparam int COORD_W   = 5;
	localparam int DIR_W     = 2;
	localparam int S_FIELD_W = 2 * COORD_W + DIR_W;
	localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
	localparam int M_FIELD_W = 2 * COORD_W + 2;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_YP = 2'd0,
		DIR_XP = 2'd1,
		DIR_YM = 2'd2,
		DIR_XM = 2'd3
	} dir_e;

	// Pending relabel: every label equal to drop becomes keep.
	typedef struct packed {
		logic   valid;
		label_t drop;
		label_t keep;
	} subst_t;

	typedef struct packed {
		logic   shift;
		subst_t subst;
	} ring_ctl_t;

	function automatic label_t relabel(label_t lbl, subst_t s);
		return (s.valid && (lbl == s.drop)) ? s.keep : lbl;
	endfunction

endpackage

FILE: hw/rtl/gmsm_cell.sv
// One ring cell: holds a single set label, relabels it on the way in.
// Depends on gmsm_pkg.
module gmsm_cell
	import gmsm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  label_t    init_label,
	input  ring_ctl_t ctl,
	input  label_t    from_next,
	output label_t    label
);

	label_t label_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_q <= init_label;
		end else if (ctl.shift) begin
			label_q <= relabel(from_next, ctl.subst);
		end
	end

	assign label = label_q;

endmodule

FILE: hw/rtl/gmsm_ring.sv
// Circular chain of label cells; cell i loads from cell i+1, last from cell 0.
// Depends on gmsm_pkg and gmsm_cell.
module gmsm_ring
	import gmsm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ring_ctl_t ctl,
	output label_t    head
);

	label_t lbl [CELLS];

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam int NEXT = (i + 1) % CELLS;
		gmsm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.init_label (LABEL_W'(i)),
			.ctl        (ctl),
			.from_next  (lbl[NEXT]),
			.label      (lbl[i])
		);
	end

	assign head = lbl[0];

endmodule

FILE: hw/rtl/grid_maze_set_merger_top.sv
// Grid maze set merger, top level: controller, request/result registers, label ring.
// Depends on gmsm_pkg, gmsm_ring and grid_maze_set_merger_top_macros.svh.
//
// The block keeps one set label per cell of a SIDE x SIDE grid in a ring of
// SIDE*SIDE cells that reset straight to their own index, so there is no
// clearing pass after reset. Each input beat names a cell and a direction;
// the neighbour is found (folded back inside the grid at an edge) and the ring
// rotates once, one label past the head per cycle, to read both labels. If
// they differ, the relabel (neighbour label -> cell label) is held pending and
// applied by every cell as labels move during the next rotation, and the next
// lookup sees the relabeled values. An item passes through the accept state,
// one full rotation of the ring and a finish state that posts the result once
// the output register is free. The input is taken only while the block is
// idle; a finished result waits in the output register, so a new beat can
// start while the previous result is still unread.
`include "grid_maze_set_merger_top_macros.svh"

module grid_maze_set_merger_top
	import gmsm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] cell_x, [9:5] cell_y, [11:10] direction
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [0] merged, [5:1] wall_x, [10:6] wall_y,
	                                        // [11] all_joined
	output logic [0:0]           m_tuser    // [0] wall_kind
);

	localparam int CW1 = COORD_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t    state_q;
	label_t    pos_q;        // index of the label sitting at the ring head
	label_t    idx_a_q;
	label_t    idx_b_q;
	logic      kind_q;
	coord_t    wx_q;
	coord_t    wy_q;
	label_t    keep_q;
	label_t    drop_q;
	subst_t    subst_q;
	label_t    count_q;
	logic      m_tvalid_q;
	logic      m_merged_q;
	logic      m_kind_q;
	coord_t    m_wx_q;
	coord_t    m_wy_q;
	logic      m_joined_q;

	ring_ctl_t ring_ctl;
	label_t    head;
	label_t    head_sub;

	coord_t    ax;
	coord_t    ay;
	coord_t    bx;
	coord_t    by;
	dir_e      dir;
	logic      out_free;
	logic      merge_now;

	function automatic coord_t clamp_coord(coord_t c);
		if ({1'b0, c} >= CW1'(SIDE)) begin
			return coord_t'(SIDE - 1);
		end
		return c;
	endfunction

	function automatic label_t cell_index(coord_t x, coord_t y);
		return label_t'(x) + label_t'(y) * label_t'(SIDE);
	endfunction

	// Beat decode and neighbour selection; edges fold back inward.
	always_comb begin
		ax  = clamp_coord(s_tdata[COORD_W-1:0]);
		ay  = clamp_coord(s_tdata[2*COORD_W-1:COORD_W]);
		dir = dir_e'(s_tdata[S_FIELD_W-1:2*COORD_W]);
		bx  = ax;
		by  = ay;
		case (dir)
			DIR_YP: begin
				by = (ay == coord_t'(SIDE - 1)) ? ay - 1'b1 : ay + 1'b1;
			end
			DIR_XP: begin
				bx = (ax == coord_t'(SIDE - 1)) ? ax - 1'b1 : ax + 1'b1;
			end
			DIR_YM: begin
				by = (ay == '0) ? ay + 1'b1 : ay - 1'b1;
			end
			DIR_XM: begin
				bx = (ax == '0) ? ax + 1'b1 : ax - 1'b1;
			end
			default: begin
				bx = ax;
			end
		endcase
	end

	// Ring runs only while scanning; cells apply the pending relabel as labels move.
	assign ring_ctl.shift = (state_q == ST_SCAN);
	assign ring_ctl.subst = subst_q;

	gmsm_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.head   (head)
	);

	// Head label as it stands once the pending relabel is applied.
	assign head_sub  = relabel(head, subst_q);
	assign out_free  = !m_tvalid_q || m_tready;
	assign merge_now = (keep_q != drop_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			idx_a_q    <= '0;
			idx_b_q    <= '0;
			kind_q     <= 1'b0;
			wx_q       <= '0;
			wy_q       <= '0;
			keep_q     <= '0;
			drop_q     <= '0;
			subst_q    <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_merged_q <= 1'b0;
			m_kind_q   <= 1'b0;
			m_wx_q     <= '0;
			m_wy_q     <= '0;
			m_joined_q <= 1'b0;
		end else begin
			// In ST_FINISH the result register is reloaded below instead.
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_a_q <= cell_index(ax, ay);
						idx_b_q <= cell_index(bx, by);
						kind_q  <= (ax != bx) ? 1'b0 : 1'b1;
						wx_q    <= (ax < bx) ? ax : bx;
						wy_q    <= (ay < by) ? ay : by;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pos_q == idx_a_q) begin
						keep_q <= head_sub;
					end
					if (pos_q == idx_b_q) begin
						drop_q <= head_sub;
					end
					if (pos_q == label_t'(CELLS - 1)) begin
						pos_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q    <= 1'b1;
						m_merged_q    <= merge_now;
						m_kind_q      <= kind_q;
						m_wx_q        <= wx_q;
						m_wy_q        <= wy_q;
						subst_q.valid <= merge_now;
						subst_q.drop  <= drop_q;
						subst_q.keep  <= keep_q;
						if (merge_now && (count_q != label_t'(CELLS - 1))) begin
							count_q    <= count_q + 1'b1;
							m_joined_q <= ((count_q + 1'b1) == label_t'(CELLS - 1));
						end else begin
							m_joined_q <= (count_q == label_t'(CELLS - 1));
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({m_joined_q, m_wy_q, m_wx_q, m_merged_q});
	assign m_tuser  = m_kind_q;

	`GMSM_ASSERT_IMPLIES(a_idle_aligned, state_q != ST_SCAN, pos_q == '0, "ring out of alignment")
	`GMSM_ASSERT_NEXT(a_accept_scans, s_tvalid && s_tready, state_q == ST_SCAN, "accepted beat did not start a scan")
	`GMSM_ASSERT_IMPLIES(a_subst_distinct, subst_q.valid, subst_q.drop != subst_q.keep, "pending relabel maps a label onto itself")
	`GMSM_ASSERT_IMPLIES(a_joined_count, m_tvalid && m_joined_q, count_q == label_t'(CELLS - 1), "all_joined without full merge count")

endmodule

FILE: dv/grid_maze_set_merger_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_maze_set_merger_top: directed beats, then merge-heavy random walls.
// Depends on gmsm_pkg and the grid_maze_set_merger_top RTL; a label-grid predictor checks each result.
module grid_maze_set_merger_top_tb;
	import gmsm_pkg::*;

	// One result beat, unpacked from m_tdata / m_tuser.
	typedef struct packed {
		logic   merged;
		logic   wall_kind;
		coord_t wall_x;
		coord_t wall_y;
		logic   all_joined;
	} wall_res_t;

	// Directed stimulus row; "typed" rows carry a hand-written expectation.
	typedef struct packed {
		coord_t    x;
		coord_t    y;
		dir_e      d;
		logic      typed;
		wall_res_t want;
	} wall_row_t;

	localparam int DIRECTED_ROWS = 25;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // [4:0] cell_x, [9:5] cell_y, [11:10] direction
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // [0] merged, [5:1] wall_x, [10:6] wall_y, [11] all_joined
	logic [0:0]           m_tuser;        // [0] wall_kind

	// Predictor state: one set label per cell plus the merge counter.
	label_t    set_label [CELLS];
	int        joins;
	wall_res_t pending_walls [$];
	int        mismatches = 0;

	// 0: no idling, 1: sender idles 59%, 2: receiver stalls 59%, 3: both 6%.
	int        idle_phase = 0;

	always #1 clk = ~clk;

	grid_maze_set_merger_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Edge cases first (fold-back on all four borders, repeat walls, a closed loop),
	// then interior cells in every direction. Typed rows follow the labels at reset.
	wall_row_t wall_rows [DIRECTED_ROWS] = '{
		'{5'd0,  5'd0,  DIR_YM, 1'b1, '{1'b1, 1'b1, 5'd0,  5'd0,  1'b0}}, // -y folds to y=1
		'{5'd0,  5'd0,  DIR_YM, 1'b1, '{1'b0, 1'b1, 5'd0,  5'd0,  1'b0}}, // same wall again
		'{5'd31, 5'd31, DIR_YP, 1'b1, '{1'b1, 1'b1, 5'd31, 5'd30, 1'b0}}, // +y folds to 30
		'{5'd31, 5'd0,  DIR_XP, 1'b1, '{1'b1, 1'b0, 5'd30, 5'd0,  1'b0}}, // +x folds to 30
		'{5'd0,  5'd31, DIR_XM, 1'b1, '{1'b1, 1'b0, 5'd0,  5'd31, 1'b0}}, // -x folds to 1
		'{5'd31, 5'd30, DIR_YM, 1'b1, '{1'b1, 1'b1, 5'd31, 5'd29, 1'b0}},
		'{5'd31, 5'd30, DIR_YP, 1'b1, '{1'b0, 1'b1, 5'd31, 5'd30, 1'b0}}, // already joined
		'{5'd5,  5'd7,  DIR_YP, 1'b0, '0},
		'{5'd5,  5'd7,  DIR_XP, 1'b0, '0},
		'{5'd5,  5'd7,  DIR_YM, 1'b0, '0},
		'{5'd5,  5'd7,  DIR_XM, 1'b0, '0},
		'{5'd5,  5'd7,  DIR_XM, 1'b0, '0},
		'{5'd6,  5'd7,  DIR_XM, 1'b0, '0},
		'{5'd21, 5'd10, DIR_XP, 1'b0, '0},
		'{5'd10, 5'd21, DIR_YM, 1'b0, '0},
		'{5'd31, 5'd31, DIR_XM, 1'b0, '0},
		'{5'd0,  5'd0,  DIR_XP, 1'b0, '0},
		'{5'd0,  5'd15, DIR_XM, 1'b0, '0},
		'{5'd15, 5'd0,  DIR_YM, 1'b0, '0},
		'{5'd15, 5'd31, DIR_YP, 1'b0, '0},
		'{5'd31, 5'd15, DIR_XP, 1'b0, '0},
		'{5'd4,  5'd8,  DIR_YP, 1'b0, '0},
		'{5'd4,  5'd9,  DIR_XP, 1'b0, '0},
		'{5'd5,  5'd9,  DIR_YM, 1'b0, '0},
		'{5'd4,  5'd8,  DIR_XP, 1'b0, '0}  // closes a loop: no merge
	};

	// Index of the neighbour cell; off-grid steps fold back across the chosen cell.
	function automatic int neighbour_index(int ax, int ay, dir_e d);
		int bx;
		int by;
		bx = ax;
		by = ay;
		case (d)
			DIR_YP: by = ay + 1;
			DIR_XP: bx = ax + 1;
			DIR_YM: by = ay - 1;
			default: bx = ax - 1;
		endcase
		if (bx < 0) bx = ax + 1;
		else if (bx >= SIDE) bx = ax - 1;
		if (by < 0) by = ay + 1;
		else if (by >= SIDE) by = ay - 1;
		return bx + SIDE * by;
	endfunction

	// Applies one wall to the label grid and returns the result the block must report.
	task automatic predict_wall(input coord_t cx, input coord_t cy, input dir_e d,
	                            output wall_res_t r);
		int     ax;
		int     ay;
		int     nb;
		int     bx;
		int     by;
		label_t keep;
		label_t drop;
		ax   = (int'(cx) >= SIDE) ? SIDE - 1 : int'(cx);
		ay   = (int'(cy) >= SIDE) ? SIDE - 1 : int'(cy);
		nb   = neighbour_index(ax, ay, d);
		bx   = nb % SIDE;
		by   = nb / SIDE;
		keep = set_label[ax + SIDE * ay];
		drop = set_label[nb];
		r.merged = (keep != drop);
		if (r.merged) begin
			for (int i = 0; i < CELLS; i++)
				if (set_label[i] == drop) set_label[i] = keep;
			if (joins < CELLS - 1) joins++;
		end
		r.wall_kind  = (ax != bx) ? 1'b0 : 1'b1;
		r.wall_x     = coord_t'((ax < bx) ? ax : bx);
		r.wall_y     = coord_t'((ay < by) ? ay : by);
		r.all_joined = (joins == CELLS - 1);
	endtask

	// Looks for a wall between two different sets, scanning from a random cell.
	task automatic find_open_wall(output coord_t x, output coord_t y, output dir_e d,
	                              output bit found);
		int   start;
		int   rot;
		int   idx;
		dir_e dd;
		start = $urandom_range(CELLS - 1);
		rot   = $urandom_range(3);
		found = 1'b0;
		x     = '0;
		y     = '0;
		d     = DIR_YP;
		for (int k = 0; k < CELLS && !found; k++) begin
			idx = (start + k) % CELLS;
			for (int j = 0; j < 4 && !found; j++) begin
				dd = dir_e'((rot + j) % 4);
				if (set_label[idx] != set_label[neighbour_index(idx % SIDE, idx / SIDE, dd)]) begin
					x     = coord_t'(idx % SIDE);
					y     = coord_t'(idx / SIDE);
					d     = dd;
					found = 1'b1;
				end
			end
		end
	endtask

	// Idle cycles before the next beat: mostly short geometric gaps, now and then
	// one long enough to land anywhere in the block's pass over the ring.
	function automatic int sender_gap();
		int gap;
		int pct;
		gap = 0;
		pct = (idle_phase == 1) ? 59 : (idle_phase == 3) ? 6 : 0;
		if (idle_phase == 1 && $urandom_range(99) < 10)
			return $urandom_range(1100);
		while (gap < 200 && $urandom_range(99) < pct) gap++;
		return gap;
	endfunction

	// Called at a rising edge; returns at the edge that accepted the beat.
	// valid stays high when the next beat follows with no gap.
	task automatic send_wall(input coord_t x, input coord_t y, input dir_e d,
	                         input logic typed, input wall_res_t want);
		int        gap;
		wall_res_t pred;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({d, y, x});
		do @(posedge clk); while (!s_tready);
		predict_wall(x, y, d, pred);
		pending_walls.push_back(typed ? want : pred);
	endtask

	// Drops valid at the current edge and holds off until every result is back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_walls.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Result monitor plus receiver backpressure; values read here are the ones
	// present at the edge, before this step's nonblocking updates.
	always @(posedge clk) begin
		wall_res_t want;
		int        pct;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_walls.size() == 0) begin
				$display("%0t ns: result beat with none expected, expected none, actual %h/%h",
				         $time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = pending_walls.pop_front();
				check_field("merged",     want.merged,     m_tdata[0]);
				check_field("wall_kind",  want.wall_kind,  m_tuser[0]);
				check_field("wall_x",     want.wall_x,     m_tdata[5:1]);
				check_field("wall_y",     want.wall_y,     m_tdata[10:6]);
				check_field("all_joined", want.all_joined, m_tdata[11]);
			end
		end
		pct = (idle_phase == 2) ? 59 : (idle_phase == 3) ? 6 : 0;
		m_tready <= ($urandom_range(99) >= pct);
	end

	// Watchdog: the slowest legal run is a few ms; this is several times that.
	initial begin
		#20_000_000;
		$display("** grid_maze_set_merger_top: FAILED **");
		$finish;
	end

	initial begin
		coord_t rx;
		coord_t ry;
		dir_e   rd;
		bit     hit;
		int     n;
		for (int i = 0; i < CELLS; i++) set_label[i] = label_t'(i);
		joins = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling.
		for (n = 0; n < DIRECTED_ROWS; n++)
			send_wall(wall_rows[n].x, wall_rows[n].y, wall_rows[n].d,
			          wall_rows[n].typed, wall_rows[n].want);
		drain_results();

		// Random part: mostly walls between different sets, with plain random
		// walls mixed in. Idle phase rotates every 50 beats.
		n = 0;
		while (n < 555) begin
			idle_phase = (n / 50) % 4;
			if (n == 290) drain_results();
			hit = 1'b0;
			if (joins < CELLS - 1 && $urandom_range(99) < 88)
				find_open_wall(rx, ry, rd, hit);
			if (!hit) begin
				rx = coord_t'($urandom);
				ry = coord_t'($urandom);
				rd = dir_e'($urandom_range(3));
			end
			send_wall(rx, ry, rd, 1'b0, '0);
			n++;
		end

		drain_results();
		// Roughly one block pass, to catch stray result beats.
		repeat (1100) @(posedge clk);

		if (mismatches == 0)
			$display("** grid_maze_set_merger_top: PASSED **");
		else
			$display("** grid_maze_set_merger_top: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/gmsm_pkg.sv
hw/rtl/gmsm_cell.sv
hw/rtl/gmsm_ring.sv
hw/rtl/grid_maze_set_merger_top.sv
dv/grid_maze_set_merger_top_tb.sv
